### hdl/aging_register_slot_allocator_unit_defines.svh
// Assertion macros shared by the slot allocator RTL.
`ifndef AGING_REGISTER_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define AGING_REGISTER_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define ARSA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define ARSA_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### hdl/arsa_pkg.sv
// Types and constants of the aging slot allocator.
`timescale 1ns / 1ps

package arsa_pkg;

    localparam int SLOTS_DEF    = 18;
    localparam int KEY_BITS_DEF = 16;
    localparam int AGE_BITS_DEF = 8;

    localparam int KEY_W  = 16;
    localparam int SLOT_W = 5;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_CLEAR  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_CONST = 2'd0,
        KIND_VAR   = 2'd1,
        KIND_PARAM = 2'd2,
        KIND_TEMP  = 2'd3
    } t_kind;

    typedef struct packed {
        t_cmd             cmd;
        logic [KEY_W-1:0] key;
        t_kind            kind;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              filled_empty;
        logic              replaced;
        logic [KEY_W-1:0]  old_key;
        t_kind             old_kind;
        logic              load_constant;
    } t_rsp;

endpackage

### hdl/aging_register_slot_allocator_unit.sv
// An accepted item waits in the input register, moves into the result register and
// shows on o_valid from there. Throughput: one item per cycle while i_ready is high;
// the table lookup, slot choice and age update all settle between the input register
// and the result register. Reset (synchronous, active low) empties both registers and
// clears every slot's valid mark at once; there is no clearing pass.
`timescale 1ns / 1ps
`include "aging_register_slot_allocator_unit_defines.svh"

module aging_register_slot_allocator_unit
    import arsa_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int AGE_BITS = AGE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    // variable and parameter are interchangeable for matching
    function automatic logic kind_match(input t_kind a, input t_kind b);
        logic a_vp;
        logic b_vp;
        a_vp = (a == KIND_VAR) || (a == KIND_PARAM);
        b_vp = (b == KIND_VAR) || (b == KIND_PARAM);
        return (a == b) || (a_vp && b_vp);
    endfunction

    logic                r_in_vld;
    t_req                r_req;
    logic                r_out_vld;
    t_rsp                r_rsp;
    logic [SLOTS-1:0]    r_valid;
    logic [KEY_BITS-1:0] r_key [SLOTS];
    t_kind               r_kind [SLOTS];
    logic [AGE_BITS-1:0] r_age [SLOTS];

    logic                advance;
    logic                is_clear;
    logic [KEY_BITS-1:0] key_m;
    logic [SLOTS-1:0]    match;
    logic [SLOTS-1:0]    hit_oh;
    logic [SLOTS-1:0]    empty;
    logic [SLOTS-1:0]    empty_oh;
    logic [SLOTS-1:0]    old_oh;
    logic [SLOTS-1:0]    sel_oh;
    logic                any_hit;
    logic                any_empty;
    logic                do_age;
    logic [KEY_BITS-1:0] old_key_full;
    t_kind               old_kind_sel;
    logic [SLOT_W-1:0]   slot_sel;
    t_rsp                n_rsp;
    logic [SLOTS-1:0]    n_valid;

    assign advance  = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready  = !r_in_vld || advance;
    assign o_valid  = r_out_vld;
    assign o_rsp    = r_rsp;
    assign is_clear = (r_req.cmd == CMD_CLEAR);
    assign key_m    = KEY_BITS'(r_req.key);

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match[i] = r_valid[i] && (r_key[i] == key_m) && kind_match(r_kind[i], r_req.kind);
        end
    end

    assign empty     = ~r_valid;
    assign hit_oh    = match & (~match + SLOTS'(1));
    assign empty_oh  = empty & (~empty + SLOTS'(1));
    assign any_hit   = |match;
    assign any_empty = |empty;
    assign do_age    = any_hit || any_empty;

    // lowest slot of greatest age: older than all below it, at least as old as all above
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            old_oh[i] = 1'b1;
            for (int j = 0; j < SLOTS; j++) begin
                if (j < i) begin
                    old_oh[i] = old_oh[i] && (r_age[i] > r_age[j]);
                end else if (j > i) begin
                    old_oh[i] = old_oh[i] && (r_age[i] >= r_age[j]);
                end
            end
        end
    end

    assign sel_oh = any_hit ? hit_oh : (any_empty ? empty_oh : old_oh);

    always_comb begin
        old_key_full = '0;
        old_kind_sel = KIND_CONST;
        slot_sel     = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (old_oh[i]) begin
                old_key_full = old_key_full | r_key[i];
                old_kind_sel = t_kind'(old_kind_sel | r_kind[i]);
            end
            if (sel_oh[i]) begin
                slot_sel = slot_sel | SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_rsp = '0;
        if (!is_clear) begin
            n_rsp.slot          = slot_sel;
            n_rsp.hit           = any_hit;
            n_rsp.filled_empty  = !any_hit && any_empty;
            n_rsp.replaced      = !do_age;
            n_rsp.old_key       = do_age ? '0 : KEY_W'(old_key_full);
            n_rsp.old_kind      = do_age ? KIND_CONST : old_kind_sel;
            n_rsp.load_constant = (r_req.kind == KIND_CONST);
        end
    end

    assign n_valid = is_clear ? '0 : (r_valid | sel_oh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_valid   <= '0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_valid   <= n_valid;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload: a slot's key, kind and age are only read once its valid mark is set,
    // and writing a slot sets all three
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
        if (advance) begin
            r_rsp <= n_rsp;
            if (!is_clear) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (sel_oh[i]) begin
                        r_key[i]  <= key_m;
                        r_kind[i] <= r_req.kind;
                        r_age[i]  <= '0;
                    end else if (do_age && r_valid[i] && (r_age[i] != AGE_MAX)) begin
                        r_age[i]  <= r_age[i] + AGE_BITS'(1);
                    end
                end
            end
        end
    end

    `ARSA_ASSERT(a_clear_empties, i_clk, i_rst_n, (advance && is_clear) |=> (r_valid == '0), "clear left a slot valid")
    `ARSA_ASSERT(a_replace_when_full, i_clk, i_rst_n, (advance && n_rsp.replaced) |-> (&r_valid), "replacement with an empty slot present")
    `ARSA_ASSERT(a_fill_grows_by_one, i_clk, i_rst_n, advance |=> ($countones(r_valid) <= $countones($past(r_valid)) + 1), "more than one slot filled by one item")
    `ARSA_ASSERT(a_one_outcome, i_clk, i_rst_n, (advance && !is_clear) |-> $onehot({n_rsp.hit, n_rsp.filled_empty, n_rsp.replaced}), "lookup outcome not unique")
    `ARSA_ASSERT_ALWAYS(a_reset_idle, i_clk, (!i_rst_n) |=> (!r_out_vld && !r_in_vld && (r_valid == '0)), "block not idle after reset")

endmodule
